/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* hdl/ppts_pkg.sv */
`default_nettype none

package ppts_pkg;

  typedef enum logic [1:0] {
    STAT_LOADED = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RAN    = 2'd2,
    STAT_IDLE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // one slot of the task table
  typedef struct packed {
    logic [7:0]  tid;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remain;
    logic [7:0]  prio;
  } task_t;

  localparam int unsigned TaskW = $bits(task_t);

  // control from the sequencer to the selector
  typedef struct packed {
    logic clear;
    logic valid;
  } sel_ctl_t;

endpackage

`default_nettype wire

/* hdl/ppts_ram.sv */
`default_nettype none

module ppts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/ppts_sel.sv */
`default_nettype none

module ppts_sel import ppts_pkg::*; #(
  parameter int unsigned IW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sel_ctl_t      ctl_i,
  input  wire logic [IW-1:0] slot_i,
  input  wire task_t         entry_i,
  input  wire logic [15:0]   clock_now_i,
  output logic               found_o,
  output task_t              best_o,
  output logic [IW-1:0]      slot_o
);

  logic          found_q, found_d;
  task_t         best_q, best_d;
  logic [IW-1:0] slot_q, slot_d;
  logic          ready, better;

  assign ready = (entry_i.remain != 16'd0) && (entry_i.arrival <= clock_now_i);
  // strict compares keep the lower slot on a full tie
  assign better = !found_q ||
                  (entry_i.prio > best_q.prio) ||
                  ((entry_i.prio == best_q.prio) && (entry_i.arrival < best_q.arrival));

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    slot_d  = slot_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (ctl_i.valid && ready && better) begin
      found_d = 1'b1;
      best_d  = entry_i;
      slot_d  = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    slot_q <= slot_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;
  assign slot_o  = slot_q;

endmodule

`default_nettype wire

/* hdl/preemptive_priority_tick_scheduler.sv */
`default_nettype none

// Preemptive priority tick scheduler. The task table sits in one single-port-read RAM
// of MAX_TASKS slots. A load beat is taken while idle and its result strobes on
// done_o in the following cycle; a new beat may be started in that same cycle. A tick beat
// reads the loaded slots one per cycle through the RAM read port, so busy stays high
// through the scan and the write-back of the picked slot, and the result strobes in the
// cycle busy falls; a tick on an empty table answers like a load. Results are shown
// for exactly one cycle on done_o and cannot be held off by the receiver.
module preemptive_priority_tick_scheduler import ppts_pkg::*; #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func_i,
  input  wire logic [7:0]  task_id_i,
  input  wire logic [15:0] arrival_time_i,
  input  wire logic [15:0] burst_time_i,
  input  wire logic [7:0]  priority_value_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       ran_id_o,
  output logic             finished_o,
  output logic [15:0]      completion_time_o,
  output logic [15:0]      turnaround_time_o,
  output logic [15:0]      waiting_time_o,
  output logic             all_done_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  state_e        state_q, state_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] live_q, live_d;
  logic [15:0]   clock_q, clock_d;

  logic          done_q, done_d;
  status_e       status_q, status_d;
  logic [7:0]    ran_id_q, ran_id_d;
  logic          fin_q, fin_d;
  logic [15:0]   comp_q, comp_d;
  logic [15:0]   tat_q, tat_d;
  logic [15:0]   wait_q, wait_d;
  logic          all_done_q, all_done_d;

  logic          accept;
  logic          full;
  logic          last_slot;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  task_t         wr_data, rd_data, load_entry, best;
  logic [TaskW-1:0] rd_word;
  sel_ctl_t      sel_ctl;
  logic          found;
  logic [IW-1:0] pick_slot;
  logic [15:0]   clock_inc;

  assign accept    = start && !busy;
  assign full      = (count_q == CW'(MAX_TASKS));
  assign last_slot = ({{(CW - IW){1'b0}}, slot_q} == (count_q - CW'(1)));
  assign clock_inc = clock_q + 16'd1;
  assign rd_data   = task_t'(rd_word);

  assign load_entry = '{
    tid:     task_id_i,
    arrival: arrival_time_i,
    burst:   burst_time_i,
    remain:  burst_time_i,
    prio:    priority_value_i
  };

  ppts_ram #(
    .WIDTH(TaskW),
    .DEPTH(MAX_TASKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_word)
  );

  ppts_sel #(
    .IW(IW)
  ) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sel_ctl),
    .slot_i     (slot_q),
    .entry_i    (rd_data),
    .clock_now_i(clock_q),
    .found_o    (found),
    .best_o     (best),
    .slot_o     (pick_slot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (func_i == FUNC_TICK) && (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_slot) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // memory and selector control
  always_comb begin
    busy    = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = load_entry;
    sel_ctl = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_en         = accept;
        sel_ctl.clear = accept;
        wr_en         = accept && (func_i == FUNC_LOAD) && !full;
        wr_addr       = count_q[IW-1:0];
      end
      S_SCAN: begin
        busy          = 1'b1;
        rd_en         = !last_slot;
        rd_addr       = slot_q + IW'(1);
        sel_ctl.valid = 1'b1;
      end
      S_FIN: begin
        busy           = 1'b1;
        wr_en          = found;
        wr_addr        = pick_slot;
        wr_data        = best;
        wr_data.remain = best.remain - 16'd1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // counters and result beat
  always_comb begin
    slot_d     = (state_q == S_SCAN) ? slot_q + IW'(1) : '0;
    count_d    = count_q;
    live_d     = live_q;
    clock_d    = clock_q;
    done_d     = 1'b0;
    status_d   = STAT_LOADED;
    ran_id_d   = '0;
    fin_d      = 1'b0;
    comp_d     = '0;
    tat_d      = '0;
    wait_d     = '0;
    if ((state_q == S_IDLE) && accept) begin
      done_d = 1'b1;
      if (func_i == FUNC_LOAD) begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + CW'(1);
          if (burst_time_i != 16'd0) begin
            live_d = live_q + CW'(1);
          end
        end
      end else if (count_q == '0) begin
        status_d = STAT_IDLE;
        clock_d  = clock_inc;
      end else begin
        done_d = 1'b0;
      end
    end else if (state_q == S_FIN) begin
      done_d  = 1'b1;
      clock_d = clock_inc;
      if (found) begin
        status_d = STAT_RAN;
        ran_id_d = best.tid;
        if (best.remain == 16'd1) begin
          fin_d  = 1'b1;
          comp_d = clock_inc;
          tat_d  = clock_inc - best.arrival;
          wait_d = clock_inc - best.arrival - best.burst;
          live_d = live_q - CW'(1);
        end
      end else begin
        status_d = STAT_IDLE;
      end
    end
    all_done_d = (live_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      count_q <= '0;
      live_q  <= '0;
      clock_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      count_q <= count_d;
      live_q  <= live_d;
      clock_q <= clock_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    ran_id_q   <= ran_id_d;
    fin_q      <= fin_d;
    comp_q     <= comp_d;
    tat_q      <= tat_d;
    wait_q     <= wait_d;
    all_done_q <= all_done_d;
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign ran_id_o          = ran_id_q;
  assign finished_o        = fin_q;
  assign completion_time_o = comp_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wait_q;
  assign all_done_o        = all_done_q;

endmodule

`default_nettype wire

/* hdl/ppts_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module ppts_checker import ppts_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        func_i,
  input wire logic [7:0]  task_id_i,
  input wire logic [15:0] arrival_time_i,
  input wire logic [15:0] burst_time_i,
  input wire logic [7:0]  priority_value_i,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  ran_id_o,
  input wire logic        finished_o,
  input wire logic [15:0] completion_time_o,
  input wire logic [15:0] turnaround_time_o,
  input wire logic [15:0] waiting_time_o,
  input wire logic        all_done_o
);

  // a result beat only shows once the block is free again
  `ASSERT_CLK(a_done_not_busy, clk_i, rst_ni, done_o |-> !busy)

  // a load answers on the very next cycle
  `ASSERT_CLK(a_load_answer, clk_i, rst_ni, (start && !busy && (func_i == FUNC_LOAD)) |=> done_o)

  // only a tick makes the block busy
  `ASSERT_CLK(a_busy_from_tick, clk_i, rst_ni, $rose(busy) |-> $past(start && (func_i == FUNC_TICK)))

  // finishing implies a task ran, and without a run the run fields stay clear
  `ASSERT_CLK(a_finish_ran, clk_i, rst_ni, (done_o && finished_o) |-> (status_o == STAT_RAN))

  `ASSERT_CLK(a_norun_clear, clk_i, rst_ni,
    (done_o && (status_o != STAT_RAN)) |-> ((ran_id_o == 8'd0) && !finished_o))

endmodule

bind preemptive_priority_tick_scheduler ppts_checker u_ppts_checker (.*);

`default_nettype wire
